### rtl/akd_pkg.sv
// ---------------------------------------------------------------------------
// akd_pkg: shared types and constants of the ANSI key sequence decoder
// Byte classes, parser states, key and event codes, and the key table lookup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package akd_pkg;

   // default size of the sequence byte buffer
   localparam int SEQ_BUF_LEN_DEF = 8;
   // longest key text in the tables; only these leading bytes are compared
   localparam int KEY_TEXT_LEN = 3;

   // event kinds
   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_KEY    = 2'd1;
   localparam logic [1:0] KIND_REDRAW = 2'd2;

   // key codes
   localparam logic [7:0] KEY_UP     = 8'd0;
   localparam logic [7:0] KEY_F1     = 8'd4;
   localparam logic [7:0] KEY_ENTER  = 8'd8;
   localparam logic [7:0] KEY_TAB    = 8'd9;
   localparam logic [7:0] KEY_DELETE = 8'd10;

   // control and sequence bytes
   localparam logic [7:0] BYTE_BS      = 8'h08;
   localparam logic [7:0] BYTE_HT      = 8'h09;
   localparam logic [7:0] BYTE_FF      = 8'h0c;
   localparam logic [7:0] BYTE_CR      = 8'h0d;
   localparam logic [7:0] BYTE_ESC     = 8'h1b;
   localparam logic [7:0] BYTE_CSI_C1  = 8'h9b;
   localparam logic [7:0] BYTE_SS3_C1  = 8'h8f;
   localparam logic [7:0] BYTE_LBRACK  = 8'h5b;  // '['
   localparam logic [7:0] BYTE_O       = 8'h4f;  // 'O'
   localparam logic [7:0] BYTE_A       = 8'h41;  // 'A'
   localparam logic [7:0] BYTE_D       = 8'h44;  // 'D'
   localparam logic [7:0] BYTE_P       = 8'h50;  // 'P'
   localparam logic [7:0] BYTE_S       = 8'h53;  // 'S'
   localparam logic [7:0] BYTE_ONE     = 8'h31;  // '1'
   localparam logic [7:0] BYTE_FOUR    = 8'h34;  // '4'
   localparam logic [7:0] BYTE_TILDE   = 8'h7e;  // '~'

   // byte classes
   typedef enum logic [3:0] {
      CL_C0     = 4'd0,
      CL_INTERM = 4'd1,
      CL_PARAM  = 4'd2,
      CL_UPPER  = 4'd3,
      CL_LOWER  = 4'd4,
      CL_DEL    = 4'd5,
      CL_C1     = 4'd6,
      CL_SPEC   = 4'd7,
      CL_G1     = 4'd8
   } class_type;

   // parser states
   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_ESC     = 5'b00010,
      ST_ESC_INT = 5'b00100,
      ST_SS3     = 5'b01000,
      ST_CSI     = 5'b10000
   } state_type;

   // one decoded event, hit marks that the byte gives a result
   typedef struct packed {
      logic       hit;
      logic [1:0] kind;
      logic [7:0] code;
   } evt_type;

   // result of a key table lookup
   typedef struct packed {
      logic       hit;
      logic [7:0] code;
   } lookup_type;

   function automatic class_type byte_class(input logic [7:0] b);
      class_type cl;
      if (b <= 8'h1f)                    cl = CL_C0;
      else if (b <= 8'h2f)               cl = CL_INTERM;
      else if (b <= 8'h3f)               cl = CL_PARAM;
      else if (b <= 8'h5f)               cl = CL_UPPER;
      else if (b <= 8'h7e)               cl = CL_LOWER;
      else if (b == 8'h7f)               cl = CL_DEL;
      else if (b <= 8'h9f)               cl = CL_C1;
      else if (b == 8'ha0 || b == 8'hff) cl = CL_SPEC;
      else                               cl = CL_G1;
      return cl;
   endfunction

   // match a collected sequence against the SS3 or CSI key table
   // len is the sequence length, or zero for any length the tables lack
   function automatic lookup_type key_lookup(input logic       ss3,
                                             input logic [1:0] len,
                                             input logic [7:0] b0,
                                             input logic [7:0] b1,
                                             input logic [7:0] b2);
      lookup_type res;
      res.hit  = 1'b0;
      res.code = KEY_UP;
      // cursor keys A to D, same in both tables
      if (len == 2'd1 && b0 >= BYTE_A && b0 <= BYTE_D) begin
         res.hit  = 1'b1;
         res.code = {6'd0, b0[1:0] - 2'd1};
      end
      // SS3 function keys P to S
      else if (ss3 && len == 2'd1 && b0 >= BYTE_P && b0 <= BYTE_S) begin
         res.hit  = 1'b1;
         res.code = KEY_F1 + {6'd0, b0[1:0]};
      end
      // CSI function keys in the bracket form
      else if (!ss3 && len == 2'd2 && b0 == BYTE_LBRACK && b1 >= BYTE_A && b1 <= BYTE_D) begin
         res.hit  = 1'b1;
         res.code = KEY_F1 + {6'd0, b1[1:0] - 2'd1};
      end
      // CSI function keys in the numbered tilde form
      else if (!ss3 && len == 2'd3 && b0 == BYTE_ONE && b1 >= BYTE_ONE && b1 <= BYTE_FOUR
               && b2 == BYTE_TILDE) begin
         res.hit  = 1'b1;
         res.code = KEY_F1 + {6'd0, b1[1:0] - 2'd1};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/akd_if.sv
// ---------------------------------------------------------------------------
// akd_if: request and response channels of the ANSI key sequence decoder
// Valid/ready channels carrying terminal bytes in and decoded events out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface akd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface akd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [7:0] event_code;

   modport source (output valid, output event_kind, output event_code, input ready);
   modport sink   (input valid, input event_kind, input event_code, output ready);
endinterface

`default_nettype wire

### rtl/akd_parser.sv
// ---------------------------------------------------------------------------
// akd_parser: escape sequence parser and key table match
// Holds the parser state and collected sequence bytes, and decodes one
// byte per step into at most one event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module akd_parser #(
   parameter int SEQ_BUF_LEN = akd_pkg::SEQ_BUF_LEN_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       in_byte,
   output akd_pkg::evt_type      evt
);
   import akd_pkg::*;

   localparam int CNT_W = $clog2(SEQ_BUF_LEN + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   // only the leading bytes take part in matching, later ones just count
   logic [7:0]       head_ff [KEY_TEXT_LEN];
   logic [7:0]       head_in [KEY_TEXT_LEN];
   class_type        cl;
   logic             do_collect;
   logic             do_lookup;
   logic             is_ss3;
   logic [1:0]       seq_len;
   lookup_type       found;

   assign cl = byte_class(in_byte);

   // state transitions and direct events
   always_comb begin
      state_in   = state_ff;
      do_collect = 1'b0;
      do_lookup  = 1'b0;
      is_ss3     = 1'b0;
      cnt_in     = cnt_ff;
      evt.hit    = 1'b0;
      evt.kind   = KIND_CHAR;
      evt.code   = in_byte;
      case (state_ff)
         ST_ESC: begin
            if (cl == CL_C0 || cl == CL_DEL) begin
               state_in = ST_ESC;
            end else if (cl == CL_INTERM) begin
               state_in = ST_ESC_INT;
            end else if (in_byte == BYTE_LBRACK) begin
               state_in = ST_CSI;
               cnt_in   = '0;
            end else if (in_byte == BYTE_O) begin
               state_in = ST_SS3;
               cnt_in   = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ESC_INT: begin
            if (cl != CL_C0 && cl != CL_INTERM) state_in = ST_IDLE;
         end
         ST_SS3: begin
            is_ss3 = 1'b1;
            if (cl == CL_PARAM) begin
               do_collect = 1'b1;
            end else if (cl == CL_UPPER) begin
               do_collect = 1'b1;
               do_lookup  = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CSI: begin
            if (cl == CL_C0) begin
               state_in = ST_CSI;
            end else if (cl == CL_INTERM || cl == CL_PARAM) begin
               do_collect = 1'b1;
            end else if (cl == CL_UPPER || cl == CL_LOWER) begin
               do_collect = 1'b1;
               if (in_byte != BYTE_LBRACK) begin
                  do_lookup = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            case (cl)
               CL_C0: begin
                  if (in_byte == BYTE_ESC) begin
                     state_in = ST_ESC;
                  end else if (in_byte == BYTE_BS) begin
                     evt.hit  = 1'b1;
                     evt.kind = KIND_KEY;
                     evt.code = KEY_DELETE;
                  end else if (in_byte == BYTE_HT) begin
                     evt.hit  = 1'b1;
                     evt.kind = KIND_KEY;
                     evt.code = KEY_TAB;
                  end else if (in_byte == BYTE_FF) begin
                     evt.hit  = 1'b1;
                     evt.kind = KIND_REDRAW;
                     evt.code = 8'd0;
                  end else if (in_byte == BYTE_CR) begin
                     evt.hit  = 1'b1;
                     evt.kind = KIND_KEY;
                     evt.code = KEY_ENTER;
                  end
               end
               CL_INTERM, CL_PARAM, CL_UPPER, CL_LOWER, CL_G1: begin
                  evt.hit  = 1'b1;
                  evt.kind = KIND_CHAR;
                  evt.code = in_byte;
               end
               CL_C1: begin
                  if (in_byte == BYTE_CSI_C1) begin
                     state_in = ST_CSI;
                     cnt_in   = '0;
                  end else if (in_byte == BYTE_SS3_C1) begin
                     state_in = ST_SS3;
                     cnt_in   = '0;
                  end
               end
               CL_DEL: begin
                  evt.hit  = 1'b1;
                  evt.kind = KIND_KEY;
                  evt.code = KEY_DELETE;
               end
               default: begin
                  evt.hit = 1'b0;
               end
            endcase
         end
      endcase

      // collect into the buffer, bytes past a full buffer are dropped
      head_in = head_ff;
      if (do_collect && cnt_ff != CNT_W'(SEQ_BUF_LEN)) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff < CNT_W'(KEY_TEXT_LEN)) head_in[cnt_ff[1:0]] = in_byte;
      end

      // length of the sequence as the tables see it
      if (cnt_in == CNT_W'(1))      seq_len = 2'd1;
      else if (cnt_in == CNT_W'(2)) seq_len = 2'd2;
      else if (cnt_in == CNT_W'(3)) seq_len = 2'd3;
      else                          seq_len = 2'd0;

      found = key_lookup(is_ss3, seq_len, head_in[0], head_in[1], head_in[2]);
      if (do_lookup) begin
         evt.hit  = found.hit;
         evt.kind = KIND_KEY;
         evt.code = found.code;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else if (step) begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // sequence bytes
   always_ff @(posedge clock) begin
      if (step) head_ff <= head_in;
   end

endmodule

`default_nettype wire

### rtl/ansi_key_sequence_decoder_top.sv
// ---------------------------------------------------------------------------
// ansi_key_sequence_decoder_top: ANSI terminal key sequence decoder
// Turns terminal bytes into plain characters, named keys and redraw events.
// ---------------------------------------------------------------------------
//
//   channel | direction | payload                  | carries
//   --------+-----------+--------------------------+-------------------------
//   req_ch  | in        | in_byte[7:0]             | one terminal byte
//   rsp_ch  | out       | event_kind[1:0],         | zero or one event per
//           |           | event_code[7:0]          | byte
//
// One byte per cycle sustained while rsp_ch takes events. A byte is held in
// the input register, decoded by the parser, and its event, if any, is
// registered in the result register. Reset clears the parser state and
// both pipeline valid flags. A stall on rsp_ch holds the result register;
// the input register still takes a byte if empty, else req_ch.ready drops.
//
`timescale 1ns / 1ps
`default_nettype none

module ansi_key_sequence_decoder_top #(
   parameter int SEQ_BUF_LEN = akd_pkg::SEQ_BUF_LEN_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   akd_req_if.sink   req_ch,
   akd_rsp_if.source rsp_ch
);
   import akd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff;
   logic [7:0] rsp_code_ff;
   logic       step;
   logic       req_take;
   evt_type    evt;

   // the held byte moves on when the result register is free or emptying
   assign step     = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !in_valid_ff || step;

   akd_parser #(
      .SEQ_BUF_LEN(SEQ_BUF_LEN)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte_ff),
      .evt     (evt)
   );

   // pipeline valid flags
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)  in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (step)              rsp_valid_in = evt.hit;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input and result payload
   always_ff @(posedge clock) begin
      if (req_take) in_byte_ff <= req_ch.in_byte;
      if (step) begin
         rsp_kind_ff <= evt.kind;
         rsp_code_ff <= evt.code;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.event_kind = rsp_kind_ff;
   assign rsp_ch.event_code = rsp_code_ff;

endmodule

`default_nettype wire

### rtl/akd_checker.sv
// ---------------------------------------------------------------------------
// akd_checker: port level checks of the ANSI key sequence decoder
// Watches the response channel for stable requests and legal event codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module akd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_code
);
   import akd_pkg::*;

   // a stalled request stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp request dropped while stalled");

   // no request right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp request present after reset");

   // only the three event kinds appear
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_CHAR || rsp_kind == KIND_KEY
                     || rsp_kind == KIND_REDRAW))
      else $error("illegal event kind");

   // named keys stay within the key codes, redraw carries code zero
   a_key_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_KEY |-> rsp_code <= KEY_DELETE)
      else $error("illegal key code");

   a_redraw_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_REDRAW |-> rsp_code == 8'd0)
      else $error("redraw with nonzero code");

endmodule

bind ansi_key_sequence_decoder_top akd_checker u_akd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_kind  (rsp_ch.event_kind),
   .rsp_code  (rsp_ch.event_code)
);

`default_nettype wire

### tb/ansi_key_event_checker.sv
// ---------------------------------------------------------------------------
// ansi_key_event_checker: scoreboard for the ANSI key sequence decoder
// Watches the request and event channels, runs its own parser on every
// accepted byte and compares each delivered event with the oldest one due.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ansi_key_event_checker (
   input  logic clock,
   input  logic reset,
   akd_req_if   req_mon,
   akd_rsp_if   rsp_mon,
   output int   fail_count,
   output int   events_pending
);
   import akd_pkg::*;

   localparam int BUF_LEN      = SEQ_BUF_LEN_DEF;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] code;
   } key_event_type;

   // events still due from the block, oldest first
   key_event_type due_events[$];

   // parser copy
   state_type  parse_st;
   logic [3:0] seq_len;
   logic [7:0] seq_buf [BUF_LEN];

   int fail_total = 0;
   int due_total  = 0;

   assign fail_count     = fail_total;
   assign events_pending = due_total;

   // range class of a terminal byte
   function automatic class_type classify_byte(input logic [7:0] b);
      if (b[7:5] == 3'b000)                return CL_C0;
      if (b[7:4] == 4'h2)                  return CL_INTERM;
      if (b[7:4] == 4'h3)                  return CL_PARAM;
      if (b[7:5] == 3'b010)                return CL_UPPER;
      if (b == 8'h7f)                      return CL_DEL;
      if (b[7:5] == 3'b011)                return CL_LOWER;
      if (b[7:5] == 3'b100)                return CL_C1;
      if (b == 8'ha0 || b == 8'hff)        return CL_SPEC;
      return CL_G1;
   endfunction

   // append to the sequence buffer, bytes past its end are dropped
   function automatic void stash_byte(input logic [7:0] b);
      if (int'(seq_len) < BUF_LEN) begin
         seq_buf[seq_len] = b;
         seq_len          = seq_len + 4'd1;
      end
   endfunction

   // key code of the collected sequence, -1 when no entry matches
   function automatic int match_key(input logic ss3);
      if (seq_len == 4'd1) begin
         if (seq_buf[0] >= BYTE_A && seq_buf[0] <= BYTE_D)
            return int'(KEY_UP) + int'(seq_buf[0] - BYTE_A);
         if (ss3 && seq_buf[0] >= BYTE_P && seq_buf[0] <= BYTE_S)
            return int'(KEY_F1) + int'(seq_buf[0] - BYTE_P);
      end
      if (!ss3 && seq_len == 4'd2 && seq_buf[0] == BYTE_LBRACK
          && seq_buf[1] >= BYTE_A && seq_buf[1] <= BYTE_D)
         return int'(KEY_F1) + int'(seq_buf[1] - BYTE_A);
      if (!ss3 && seq_len == 4'd3 && seq_buf[0] == BYTE_ONE
          && seq_buf[1] >= BYTE_ONE && seq_buf[1] <= BYTE_FOUR && seq_buf[2] == BYTE_TILDE)
         return int'(KEY_F1) + int'(seq_buf[1] - BYTE_ONE);
      return -1;
   endfunction

   // advance the parser by one byte and queue the event it causes
   function automatic void decode_byte(input logic [7:0] b);
      class_type     cls;
      int            key;
      logic          hit;
      key_event_type ev;
      cls = classify_byte(b);
      key = -1;
      hit = 1'b0;
      ev  = '0;
      case (parse_st)
         ST_ESC: begin
            if (cls == CL_C0 || cls == CL_DEL) begin
               parse_st = ST_ESC;
            end else if (cls == CL_INTERM) begin
               parse_st = ST_ESC_INT;
            end else if (b == BYTE_LBRACK) begin
               parse_st = ST_CSI;
               seq_len  = '0;
            end else if (b == BYTE_O) begin
               parse_st = ST_SS3;
               seq_len  = '0;
            end else begin
               parse_st = ST_IDLE;
            end
         end
         ST_ESC_INT: begin
            if (cls != CL_C0 && cls != CL_INTERM) parse_st = ST_IDLE;
         end
         ST_SS3: begin
            if (cls == CL_PARAM) begin
               stash_byte(b);
            end else if (cls == CL_UPPER) begin
               stash_byte(b);
               key      = match_key(1'b1);
               parse_st = ST_IDLE;
            end else begin
               parse_st = ST_IDLE;
            end
         end
         ST_CSI: begin
            if (cls == CL_INTERM || cls == CL_PARAM) begin
               stash_byte(b);
            end else if (cls == CL_UPPER || cls == CL_LOWER) begin
               stash_byte(b);
               // an opening bracket keeps collecting, anything else ends it
               if (b != BYTE_LBRACK) begin
                  key      = match_key(1'b0);
                  parse_st = ST_IDLE;
               end
            end else if (cls != CL_C0) begin
               parse_st = ST_IDLE;
            end
         end
         default: begin
            parse_st = ST_IDLE;
            case (cls)
               CL_C0: begin
                  if (b == BYTE_ESC) begin
                     parse_st = ST_ESC;
                  end else if (b == BYTE_BS) begin
                     key = int'(KEY_DELETE);
                  end else if (b == BYTE_HT) begin
                     key = int'(KEY_TAB);
                  end else if (b == BYTE_CR) begin
                     key = int'(KEY_ENTER);
                  end else if (b == BYTE_FF) begin
                     hit     = 1'b1;
                     ev.kind = KIND_REDRAW;
                     ev.code = '0;
                  end
               end
               CL_INTERM, CL_PARAM, CL_UPPER, CL_LOWER, CL_G1: begin
                  hit     = 1'b1;
                  ev.kind = KIND_CHAR;
                  ev.code = b;
               end
               CL_C1: begin
                  if (b == BYTE_CSI_C1) begin
                     parse_st = ST_CSI;
                     seq_len  = '0;
                  end else if (b == BYTE_SS3_C1) begin
                     parse_st = ST_SS3;
                     seq_len  = '0;
                  end
               end
               CL_DEL: begin
                  key = int'(KEY_DELETE);
               end
               default: begin
               end
            endcase
         end
      endcase
      if (key >= 0) begin
         hit     = 1'b1;
         ev.kind = KIND_KEY;
         ev.code = 8'(key);
      end
      if (hit) due_events.push_back(ev);
   endfunction

   // compare delivered events first, then predict from the accepted request
   always @(posedge clock) begin
      key_event_type want;
      if (reset) begin
         parse_st = ST_IDLE;
         seq_len  = '0;
         due_events.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_events.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT)
                  $display("unexpected event: kind %0d code 0x%02h",
                           rsp_mon.event_kind, rsp_mon.event_code);
            end else begin
               want = due_events.pop_front();
               if (want.kind !== rsp_mon.event_kind || want.code !== rsp_mon.event_code) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT)
                     $display({"event mismatch: expected kind %0d code 0x%02h, ",
                               "got kind %0d code 0x%02h"},
                              want.kind, want.code, rsp_mon.event_kind, rsp_mon.event_code);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) decode_byte(req_mon.in_byte);
      end
      due_total = due_events.size();
   end

endmodule

### tb/ansi_key_sequence_decoder_top_test.sv
// ---------------------------------------------------------------------------
// ansi_key_sequence_decoder_top_test: testbench of the ANSI key decoder
// Feeds edge bytes, key sequences, broken sequences and noise through the
// request channel under varying back pressure; the event checker scores it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ansi_key_sequence_decoder_top_test;
   import akd_pkg::*;

   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         PHASE_BYTES  = 630;
   localparam int         DRAIN_CYCLES = 20;
   localparam logic [7:0] BYTE_DEL     = 8'h7f;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic [7:0] req_byte  = 8'h00;
   logic       rsp_ready = 1'b0;

   int send_idle_pct = 13;
   int recv_idle_pct = 66;
   int bytes_sent    = 0;
   int cycle_count   = 0;
   int fail_count;
   int events_pending;

   // edge bytes, control keys, and one of each sequence intro
   logic [7:0] directed_bytes[$] = '{
      8'h00, 8'hff, 8'h20, BYTE_TILDE, BYTE_DEL, BYTE_BS, BYTE_HT, BYTE_CR, BYTE_FF,
      8'h80, 8'ha0, 8'ha1, 8'hfe,
      BYTE_ESC, BYTE_LBRACK, BYTE_A,
      BYTE_SS3_C1, BYTE_S,
      BYTE_CSI_C1, BYTE_ONE, BYTE_FOUR, BYTE_TILDE,
      BYTE_ESC, BYTE_O, BYTE_P
   };

   akd_req_if req_ch ();
   akd_rsp_if rsp_ch ();

   assign req_ch.valid   = req_valid;
   assign req_ch.in_byte = req_byte;
   assign rsp_ch.ready   = rsp_ready;

   ansi_key_sequence_decoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ansi_key_event_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .fail_count     (fail_count),
      .events_pending (events_pending)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ansi_key_sequence_decoder_top_test: done, errors");
         $finish;
      end
   end

   // event receiver back pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   function automatic logic [7:0] pick_byte(input int lo, input int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   // offer one request, with random gaps, and wait until it is taken
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte  <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // one random burst: noise, text, CSI or SS3 sequences, escape intermediates
   task automatic send_random_burst();
      logic [7:0] burst[$];
      int         pick;
      int         form;
      int         n;
      pick = $urandom_range(99, 0);
      if (pick < 25) begin
         // noise over the whole byte range
         n = $urandom_range(4, 1);
         repeat (n) burst.push_back(pick_byte(0, 255));
      end else if (pick < 38) begin
         // printable and G1 text
         n = $urandom_range(5, 1);
         repeat (n) burst.push_back($urandom_range(3, 0) == 0 ? pick_byte(8'ha1, 8'hfe)
                                                             : pick_byte(8'h20, 8'h7e));
      end else if (pick < 75) begin
         // CSI sequence, 8-bit or escape form
         if ($urandom_range(1, 0) == 1) begin
            burst.push_back(BYTE_CSI_C1);
         end else begin
            burst.push_back(BYTE_ESC);
            if ($urandom_range(4, 0) == 0)
               burst.push_back($urandom_range(1, 0) == 1 ? BYTE_DEL : pick_byte(8'h00, 8'h1f));
            burst.push_back(BYTE_LBRACK);
         end
         form = $urandom_range(5, 0);
         case (form)
            0: burst.push_back(pick_byte(BYTE_A, BYTE_D + 8'd1));
            1: begin
               burst.push_back(BYTE_LBRACK);
               burst.push_back(pick_byte(BYTE_A - 8'd1, BYTE_D + 8'd1));
            end
            2: begin
               burst.push_back(BYTE_ONE);
               burst.push_back(pick_byte(8'h30, 8'h35));
               burst.push_back($urandom_range(3, 0) == 0 ? pick_byte(8'h40, 8'h7e) : BYTE_TILDE);
            end
            3: begin
               // random parameters, long enough at times to overflow the buffer
               n = $urandom_range(12, 0);
               repeat (n) burst.push_back(pick_byte(8'h20, 8'h3f));
               burst.push_back(pick_byte(8'h40, 8'h7e));
            end
            4: begin
               // control bytes inside a sequence are skipped
               burst.push_back(BYTE_ONE);
               burst.push_back(pick_byte(8'h00, 8'h1f));
               burst.push_back(pick_byte(BYTE_ONE, BYTE_FOUR));
               burst.push_back(pick_byte(8'h00, 8'h1f));
               burst.push_back(BYTE_TILDE);
            end
            default: begin
               // broken sequence
               n = $urandom_range(2, 0);
               repeat (n) burst.push_back(pick_byte(8'h30, 8'h3f));
               burst.push_back(pick_byte(8'h7f, 8'hff));
            end
         endcase
      end else if (pick < 92) begin
         // SS3 sequence, 8-bit or escape form
         if ($urandom_range(1, 0) == 1) begin
            burst.push_back(BYTE_SS3_C1);
         end else begin
            burst.push_back(BYTE_ESC);
            burst.push_back(BYTE_O);
         end
         form = $urandom_range(3, 0);
         if (form <= 1) begin
            burst.push_back(pick_byte(BYTE_A, BYTE_S));
         end else if (form == 2) begin
            n = $urandom_range(10, 0);
            repeat (n) burst.push_back(pick_byte(8'h30, 8'h3f));
            burst.push_back(pick_byte(8'h40, 8'h5f));
         end else begin
            burst.push_back($urandom_range(1, 0) == 1 ? pick_byte(8'h00, 8'h2f)
                                                      : pick_byte(8'h60, 8'hff));
         end
      end else begin
         // escape with intermediates, then any terminator
         burst.push_back(BYTE_ESC);
         n = $urandom_range(3, 1);
         repeat (n) burst.push_back($urandom_range(3, 0) == 0 ? pick_byte(8'h00, 8'h1f)
                                                             : pick_byte(8'h20, 8'h2f));
         burst.push_back(pick_byte(8'h30, 8'hff));
      end
      foreach (burst[i]) send_byte(burst[i]);
   endtask

   // stimulus and verdict
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 13;
               recv_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 13;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 0) begin
            foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
         end
         while (bytes_sent < (phase + 1) * PHASE_BYTES) send_random_burst();
      end
      req_valid <= 1'b0;

      // drain outstanding events, then let the pipeline settle
      @(posedge clock);
      while (events_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("ansi_key_sequence_decoder_top_test: done, clean");
      end else begin
         $display("ansi_key_sequence_decoder_top_test: done, errors");
      end
      $finish;
   end

endmodule
